@@ src/tlb_pkg.sv @@
package tlb_pkg;

  localparam int ENTRIES_DEF = 32;
  localparam int PAGE_BITS   = 20;
  localparam int FRAME_BITS  = 20;
  localparam int LFSR_W      = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  localparam int CFG_ADDR_W = 3;
  localparam logic MODE_LRU    = 1'b0;
  localparam logic MODE_RANDOM = 1'b1;
  localparam logic REG_MODE    = 1'b0;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_FILL   = 2'd1,
    KIND_INVAL  = 2'd2,
    KIND_FLUSH  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [PAGE_BITS-1:0]  vpn;
    logic [FRAME_BITS-1:0] pfn;
  } in_item_t;

  typedef struct packed {
    logic                  hit;
    logic [FRAME_BITS-1:0] frame_out;
    logic                  evicted_valid;
    logic [PAGE_BITS-1:0]  evicted_page;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOD,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic mod_clr;
    logic mod_step;
    logic update;
  } tlb_cmd_t;

  typedef struct packed {
    logic is_fill;
    logic full;
  } tlb_stat_t;

endpackage

@@ src/tlb_ctrl.sv @@
module tlb_ctrl
  import tlb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      mode,
  input  tlb_stat_t stat,
  output logic      busy,
  output logic      out_valid,
  output tlb_cmd_t  cmd
);

  state_t     state_r, state_nxt;
  logic       cnt_r, cnt_nxt;
  logic       out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cnt_nxt = 1'b0;
        if (stat.is_fill && stat.full && (mode == MODE_RANDOM)) state_nxt = ST_MOD;
        else state_nxt = ST_UPDATE;
      end
      ST_MOD: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 1'b1) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state_r != ST_IDLE);
    cmd.load     = (state_r == ST_IDLE) && start;
    cmd.scan     = (state_r == ST_SCAN);
    cmd.mod_clr  = (state_r == ST_SCAN);
    cmd.mod_step = (state_r == ST_MOD);
    cmd.update   = (state_r == ST_UPDATE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= (state_r == ST_UPDATE);
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ src/tlb_dp.sv @@
module tlb_dp
  import tlb_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  logic       mode,
  input  tlb_cmd_t   cmd,
  output tlb_stat_t  stat,
  output out_item_t  out_item
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int MOD_SH = LFSR_W + IW;
  localparam int MOD_MUL_I = ((1 << MOD_SH) + ENTRIES - 1) / ENTRIES;
  localparam logic [LFSR_W:0] MOD_MUL = (LFSR_W+1)'(MOD_MUL_I);
  localparam logic [IW-1:0] ENT_LO = IW'(ENTRIES);
  localparam int PW = LFSR_W + MOD_SH;

  in_item_t              item_r;
  logic [ENTRIES-1:0]    valid_r;
  logic [PAGE_BITS-1:0]  page_r  [ENTRIES];
  logic [FRAME_BITS-1:0] frame_r [ENTRIES];
  logic [ENTRIES-1:0]    match_r;
  logic [IW-1:0]         hit_idx_r, inv_idx_r;
  logic                  hit_any_r, inv_any_r;
  logic [IW-1:0]         mod_r, mod_nxt;
  logic [LFSR_W-1:0]     mod_q_r;
  logic [LFSR_W-1:0]     lfsr_r;
  out_item_t             out_r;

  logic [ENTRIES-1:0]    match_c;
  logic [IW-1:0]         hit_idx_c, inv_idx_c;

  always_comb begin
    hit_idx_c = '0;
    inv_idx_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match_c[i] = valid_r[i] && (page_r[i] == item_r.vpn);
      if (match_c[i]) hit_idx_c = IW'(i);
      if (!valid_r[i]) inv_idx_c = IW'(i);
    end
  end

  // quotient by reciprocal multiply, then remainder from its low bits
  logic [PW-1:0]     mod_prod;
  logic [LFSR_W-1:0] mod_q;
  logic [IW-1:0]     mod_qd;
  always_comb begin
    mod_prod = PW'(lfsr_r) * PW'(MOD_MUL);
    mod_q    = mod_prod[MOD_SH +: LFSR_W];
    mod_qd   = IW'(mod_q_r) * ENT_LO;
    mod_nxt  = lfsr_r[IW-1:0] - mod_qd;
  end

  logic                  is_lookup, is_fill, lru, evict, do_move, do_write;
  logic [IW-1:0]         pos;
  logic [PAGE_BITS-1:0]  wr_page;
  logic [FRAME_BITS-1:0] wr_frame;
  logic                  fb;

  always_comb begin
    is_lookup = (item_r.kind == KIND_LOOKUP);
    is_fill   = (item_r.kind == KIND_FILL);
    lru       = (mode == MODE_LRU);
    evict     = is_fill && !inv_any_r;
    if (is_lookup) pos = hit_idx_r;
    else if (inv_any_r) pos = inv_idx_r;
    else if (lru) pos = IW'(ENTRIES - 1);
    else pos = mod_r;
    do_move  = lru && ((is_lookup && hit_any_r) || is_fill);
    do_write = is_fill;
    wr_page  = is_fill ? item_r.vpn : page_r[pos];
    wr_frame = is_fill ? item_r.pfn : frame_r[pos];
    fb       = lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.scan) begin
      match_r   <= match_c;
      hit_idx_r <= hit_idx_c;
      inv_idx_r <= inv_idx_c;
      hit_any_r <= |match_c;
      inv_any_r <= ~&valid_r;
    end
    if (cmd.mod_clr) mod_r <= '0;
    else if (cmd.mod_step) begin
      mod_q_r <= mod_q;
      mod_r   <= mod_nxt;
    end
    if (cmd.update) begin
      out_r.hit           <= is_lookup && hit_any_r;
      out_r.frame_out     <= (is_lookup && hit_any_r) ? frame_r[pos] : '0;
      out_r.evicted_valid <= evict;
      out_r.evicted_page  <= evict ? page_r[pos] : '0;
      if (do_move) begin
        page_r[0]  <= wr_page;
        frame_r[0] <= wr_frame;
        for (int i = 1; i < ENTRIES; i++) begin
          if (i <= int'(pos)) begin
            page_r[i]  <= page_r[i-1];
            frame_r[i] <= frame_r[i-1];
          end
        end
      end else if (do_write) begin
        page_r[pos]  <= wr_page;
        frame_r[pos] <= wr_frame;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      lfsr_r  <= LFSR_SEED;
    end else if (cmd.update) begin
      case (item_r.kind)
        KIND_INVAL: valid_r <= valid_r & ~match_r;
        KIND_FLUSH: valid_r <= '0;
        default: begin
          if (do_move) begin
            valid_r[0] <= 1'b1;
            for (int i = 1; i < ENTRIES; i++) begin
              if (i <= int'(pos)) valid_r[i] <= valid_r[i-1];
            end
          end else if (do_write) begin
            valid_r[pos] <= 1'b1;
          end
        end
      endcase
      if (evict && !lru) lfsr_r <= {fb, lfsr_r[LFSR_W-1:1]};
    end
  end

  assign stat.is_fill = (item_r.kind == KIND_FILL);
  assign stat.full    = &valid_r;
  assign out_item     = out_r;

endmodule

@@ src/tlb_lru_random_replace.sv @@
// channel | ports                                   | accepted when
// input   | start, busy, in_item                    | start && !busy
// result  | out_valid, out_item                     | out_valid (one cycle)
// config  | psel, penable, pwrite, paddr, pwdata... | psel && penable && pwrite
// An item passes through start, scan and update; a fill that evicts in random
// mode adds the MOD state for the reciprocal-multiply reduction of the LFSR by ENTRIES.
// The result shows in the cycle after the update, when busy is already low.
// Reset: synchronous, active low; all entries invalid, LFSR at its seed.
// The receiver cannot stall; results are never held.
module tlb_lru_random_replace
  import tlb_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic      mode_r;
  tlb_cmd_t  cmd;
  tlb_stat_t stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? {31'b0, mode_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LRU;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MODE)) begin
      mode_r <= pwdata[0];
    end
  end

  tlb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .mode      (mode_r),
    .stat      (stat),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  tlb_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .mode     (mode_r),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_hit_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.hit && out_item.evicted_valid)) else $error("hit and evict");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.hit |-> out_item.frame_out == '0) else $error("frame on miss");
`endif

endmodule
